// ----- rtl/bes_pkg.sv -----
// Bezier easing solver package: constants, controller/datapath command and status types.
// No dependencies.
`default_nettype none
package bes_pkg;
	localparam int MAX_INNER_POINTS_DEF = 6;
	localparam int FRACTION_BITS_DEF    = 14;
	localparam int Q14_W                = 16;
	localparam int CFG_W                = 32;
	localparam int CFG_IDX_W            = 3;
	localparam int LIMIT_W              = 7;
	localparam int COUNT_W              = 3;

	localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_ONE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_SIX   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd7;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 7'd100;

	localparam logic ACT_SOLVE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	// datapath commands
	typedef struct packed {
		logic load;       // take item, set t
		logic start_x;    // evaluate x(t) and slope
		logic start_y;    // evaluate y(t)
		logic start_div;  // Newton quotient
		logic upd_t;      // t -= delta
	} bes_cmd_t;

	typedef struct packed {
		logic curve_done;
		logic div_done;
		logic slope_zero;
		logic delta_zero;
	} bes_sts_t;
endpackage
`default_nettype wire

// ----- rtl/bezier_easing_solver_core.sv -----
// Bezier easing solver top level: config registers, controller and datapath.
// Depends on bes_pkg, bes_ctrl, bes_dpath.
// An evaluation runs an x and a y curve pass; a solve first adds, per Newton step,
// an x curve pass (with slope) and a divide.
// One item at a time; the divider and the single lerp unit set the rate.
// arst_n clears control and config registers (iteration_limit resets to 100).
`default_nettype none
module bezier_easing_solver_core #(
	parameter int MAX_INNER_POINTS = bes_pkg::MAX_INNER_POINTS_DEF,
	parameter int FRACTION_BITS    = bes_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bes_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bes_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            action,
	input  wire logic signed [15:0]              position,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [15:0]                   x_value,
	output logic signed [15:0]                   y_value,
	output logic signed [15:0]                   param_t,
	output logic                                 converged,
	output logic                                 zero_slope
);
	logic [bes_pkg::COUNT_W-1:0] inner_count_q;
	logic [MAX_INNER_POINTS*32-1:0] points_q;
	logic [bes_pkg::LIMIT_W-1:0] limit_q;
	bes_pkg::bes_cmd_t cmd;
	bes_pkg::bes_sts_t sts;
	logic busy, in_fire, out_fire;
	logic signed [15:0] xv, yv;
	logic first_q; // first finished curve of the wrap-up is x, second y

	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// config beats; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_count_q <= '0;
			points_q <= '0;
			limit_q <= bes_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bes_pkg::REG_INNER_COUNT)
				inner_count_q <= cfg_data[bes_pkg::COUNT_W-1:0];
			else if (cfg_index == bes_pkg::REG_ITER_LIMIT)
				limit_q <= cfg_data[bes_pkg::LIMIT_W-1:0];
			else if (cfg_index >= bes_pkg::REG_POINT_ONE && cfg_index <= bes_pkg::REG_POINT_SIX)
				for (int i = 0; i < MAX_INNER_POINTS; i++)
					if (int'(cfg_index) == i + 1) points_q[i*32 +: 32] <= cfg_data;
		end
	end

	bes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .action(action),
		.iteration_limit(limit_q), .out_fire(out_fire), .sts(sts), .cmd(cmd),
		.busy(busy), .out_valid(out_valid), .conv(converged), .flat(zero_slope)
	);

	bes_dpath #(.MAX_INNER_POINTS(MAX_INNER_POINTS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .action(action), .position(position),
		.inner_count(inner_count_q), .points(points_q), .sts(sts),
		.x_value(xv), .y_value(yv), .param_t(param_t)
	);

	// the datapath latches each finished curve; keep x from the wrap-up x pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b0;
		else if (cmd.start_y) first_q <= 1'b1;
		else if (in_fire) first_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.start_y) x_value <= xv;
	end
	assign y_value = first_q ? yv : xv;

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(converged && zero_slope)) else $error("both flags set");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input open while result held");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ----- rtl/bes_ctrl.sv -----
// Bezier easing solver controller: sequences evaluations and Newton steps.
// Depends on bes_pkg.
`default_nettype none
module bes_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_fire,
	input  wire logic                         action,
	input  wire logic [bes_pkg::LIMIT_W-1:0]  iteration_limit,
	input  wire logic                         out_fire,
	input  wire bes_pkg::bes_sts_t            sts,
	output bes_pkg::bes_cmd_t                 cmd,
	output logic                              busy,
	output logic                              out_valid,
	output logic                              conv,
	output logic                              flat
);
	localparam logic [3:0] ST_IDLE = 4'd0, ST_XN = 4'd1, ST_XNW = 4'd2, ST_DIV = 4'd3,
		ST_DIVW = 4'd4, ST_FX = 4'd5, ST_FXW = 4'd6, ST_FY = 4'd7, ST_FYW = 4'd8,
		ST_OUT = 4'd9;
	logic [3:0] state_q;
	logic [bes_pkg::LIMIT_W-1:0] left_q;
	logic conv_q, flat_q;

	always_comb begin
		cmd = '0;
		cmd.load      = in_fire;
		cmd.start_x   = (state_q == ST_XN) || (state_q == ST_FX);
		cmd.start_div = (state_q == ST_DIV);
		cmd.start_y   = (state_q == ST_FY);
		cmd.upd_t     = (state_q == ST_DIVW) && sts.div_done;
	end
	assign busy = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign conv = conv_q;
	assign flat = flat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q <= '0;
			conv_q <= 1'b0;
			flat_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) begin
					conv_q <= 1'b0;
					flat_q <= 1'b0;
					left_q <= (iteration_limit == '0) ? 7'd1 : iteration_limit;
					state_q <= (action == bes_pkg::ACT_EVAL) ? ST_FX : ST_XN;
				end
				ST_XN: state_q <= ST_XNW;
				ST_XNW: if (sts.curve_done) begin
					if (sts.slope_zero) begin
						flat_q <= 1'b1;
						state_q <= ST_FX;
					end else state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_DIVW;
				ST_DIVW: if (sts.div_done) begin
					left_q <= left_q - 7'd1;
					if (sts.delta_zero) begin
						conv_q <= 1'b1;
						state_q <= ST_FX;
					end else if (left_q == 7'd1) state_q <= ST_FX;
					else state_q <= ST_XN;
				end
				ST_FX: state_q <= ST_FXW;
				ST_FXW: if (sts.curve_done) state_q <= ST_FY;
				ST_FY: state_q <= ST_FYW;
				ST_FYW: if (sts.curve_done) state_q <= ST_OUT;
				ST_OUT: if (out_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/bes_dpath.sv -----
// Bezier easing solver datapath: de Casteljau unit (one lerp per cycle),
// restoring divider (one quotient bit per cycle), t register and result registers.
// Depends on bes_pkg.
`default_nettype none
module bes_dpath #(
	parameter int MAX_INNER_POINTS = bes_pkg::MAX_INNER_POINTS_DEF,
	parameter int FRACTION_BITS    = bes_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bes_pkg::bes_cmd_t             cmd,
	input  wire logic                          action,
	input  wire logic signed [15:0]            position,
	input  wire logic [bes_pkg::COUNT_W-1:0]   inner_count,
	input  wire logic [MAX_INNER_POINTS*32-1:0] points,
	output bes_pkg::bes_sts_t                  sts,
	output logic signed [15:0]                 x_value,
	output logic signed [15:0]                 y_value,
	output logic signed [15:0]                 param_t
);
	localparam int W   = FRACTION_BITS + 2;           // internal value, [-2,2)
	localparam int NP  = MAX_INNER_POINTS + 2;
	localparam int IW  = $clog2(NP);
	localparam int DW  = W + 4;                        // slope: n*(diff)
	localparam int NW  = W + 2 + FRACTION_BITS;        // dividend magnitude
	localparam int CW  = $clog2(NW + 1);
	localparam logic signed [W-1:0] SAT_HI = {2'b01, {FRACTION_BITS{1'b1}}};
	localparam logic signed [W-1:0] SAT_LO = {2'b10, {FRACTION_BITS{1'b0}}};

	function automatic logic signed [W-1:0] sat_w(input logic signed [W+4:0] v);
		if (v > (W+5)'(SAT_HI)) return SAT_HI;
		if (v < (W+5)'(SAT_LO)) return SAT_LO;
		return v[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] from_q(input logic signed [15:0] v);
		logic signed [W+20:0] e;
		e = (W+21)'(v);
		if (FRACTION_BITS >= 14) e = e <<< (FRACTION_BITS - 14);
		else e = (e + ((W+21)'(1) <<< (13 - FRACTION_BITS))) >>> (14 - FRACTION_BITS);
		if (e > (W+21)'(SAT_HI)) return SAT_HI;
		if (e < (W+21)'(SAT_LO)) return SAT_LO;
		return e[W-1:0];
	endfunction

	function automatic logic signed [15:0] to_q(input logic signed [W-1:0] v);
		logic signed [W+16:0] e;
		e = (W+17)'(v);
		if (FRACTION_BITS > 14) e = (e + ((W+17)'(1) <<< (FRACTION_BITS - 15)))
			>>> (FRACTION_BITS - 14);
		else e = e <<< (14 - FRACTION_BITS);
		if (e > 32767) return 16'sh7fff;
		if (e < -32768) return 16'sh8000;
		return e[15:0];
	endfunction

	// low bit of inner point i in the packed point bus; rows outside 1..MAX map to 0
	function automatic int pt_lsb(input int i);
		return ((i >= 1) && (i <= MAX_INNER_POINTS)) ? (i - 1) * 32 : 0;
	endfunction

	logic signed [W-1:0] t_q, target_q;
	logic                act_q;
	logic [IW-1:0]       n_q;

	// de Casteljau working row
	logic signed [W-1:0] b_q [NP];
	logic [IW-1:0]       lvl_q, idx_q;
	logic                run_q, done_q;
	logic signed [DW-1:0] slope_q;
	logic signed [W-1:0] curve_q;

	logic [IW-1:0] n_now;
	always_comb begin
		n_now = (inner_count > bes_pkg::COUNT_W'(MAX_INNER_POINTS))
			? IW'(MAX_INNER_POINTS + 1) : IW'(inner_count) + IW'(1);
	end

	logic signed [W:0]     diff;
	logic signed [2*W+1:0] prod;
	logic signed [2*W+1:0] rnd;
	always_comb begin
		diff = (W+1)'(b_q[idx_q + IW'(1)]) - (W+1)'(b_q[idx_q]);
		prod = (2*W+2)'(t_q) * (2*W+2)'(diff);
		rnd  = (prod + ((2*W+2)'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
	end

	// divider
	logic [NW-1:0] num_q, quo_q;
	logic [NW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q, drun_q, ddone_q;
	logic [CW-1:0] dcnt_q;
	logic [NW:0]   rem_sh;
	assign rem_sh = {rem_q[NW-1:0], num_q[NW-1]};

	logic signed [W+1:0]  errv;
	logic signed [NW:0]   errs;
	assign errv = (W+2)'(curve_q) - (W+2)'(target_q);
	assign errs = (NW+1)'(errv) <<< FRACTION_BITS;

	logic signed [NW:0] delta;
	assign delta = neg_q ? -(NW+1)'(quo_q) : (NW+1)'(quo_q);
	logic signed [NW+1:0] tnew;
	assign tnew = (NW+2)'(t_q) - (NW+2)'(delta);

	assign sts.curve_done = done_q;
	assign sts.div_done   = ddone_q;
	assign sts.slope_zero = (slope_q == '0);
	assign sts.delta_zero = (quo_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			drun_q <= 1'b0;
			ddone_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			ddone_q <= 1'b0;
			if (cmd.start_x || cmd.start_y) run_q <= 1'b1;
			else if (run_q && lvl_q == IW'(1) && idx_q == '0) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
			if (cmd.start_div) drun_q <= 1'b1;
			else if (drun_q && dcnt_q == CW'(1)) begin
				drun_q <= 1'b0;
				ddone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			n_q <= n_now;
			target_q <= from_q(position);
			t_q <= (action == bes_pkg::ACT_EVAL) ? from_q(position)
				: W'(1) <<< (FRACTION_BITS - 1);
			param_t <= position;
		end
		if (cmd.start_x || cmd.start_y) begin
			for (int i = 0; i < NP; i++) begin
				if (i == 0) b_q[i] <= '0;
				else if (i < int'(n_q))
					b_q[i] <= from_q(cmd.start_x ? points[pt_lsb(i)+16 +: 16]
						: points[pt_lsb(i) +: 16]);
				else b_q[i] <= SAT_HI > (W'(1) <<< FRACTION_BITS)
					? (W'(1) <<< FRACTION_BITS) : SAT_HI;
			end
			lvl_q <= n_q;
			idx_q <= '0;
		end else if (run_q) begin
			if (lvl_q == IW'(1))
				slope_q <= DW'(n_q) * (DW'(b_q[1]) - DW'(b_q[0]));
			b_q[idx_q] <= sat_w((W+5)'(b_q[idx_q]) + (W+5)'(rnd));
			if (idx_q == lvl_q - IW'(1)) begin
				idx_q <= '0;
				lvl_q <= lvl_q - IW'(1);
			end else idx_q <= idx_q + IW'(1);
			if (lvl_q == IW'(1)) curve_q <= sat_w((W+5)'(b_q[0]) + (W+5)'(rnd));
		end
		if (cmd.start_div) begin
			num_q <= errs[NW] ? NW'(-errs) : NW'(errs);
			den_q <= slope_q[DW-1] ? DW'(-slope_q) : DW'(slope_q);
			neg_q <= errs[NW] ^ slope_q[DW-1];
			rem_q <= '0;
			quo_q <= '0;
			dcnt_q <= CW'(NW);
		end else if (drun_q) begin
			num_q <= num_q << 1;
			dcnt_q <= dcnt_q - CW'(1);
			if (rem_sh >= (NW+1)'(den_q)) begin
				rem_q <= rem_sh - (NW+1)'(den_q);
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.upd_t) begin
			if (tnew > (NW+2)'(SAT_HI)) t_q <= SAT_HI;
			else if (tnew < (NW+2)'(SAT_LO)) t_q <= SAT_LO;
			else t_q <= tnew[W-1:0];
		end
		if (done_q) begin
			if (!act_q) param_t <= to_q(t_q);
			x_value <= to_q(curve_q);
			y_value <= to_q(curve_q);
		end
	end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for bezier_easing_solver_core: curve evaluation and Newton solve.
// Depends on bes_pkg and the core RTL; carries its own bit-accurate curve predictor.
`timescale 1ns / 1ps
module testbench;
	localparam int FB = 14;
	localparam int IDX_W = bes_pkg::CFG_IDX_W;
	localparam int EXP_DEPTH = 1024;
	localparam longint ONE = 64'sd1 <<< FB;
	localparam longint SAT_HI = (64'sd1 <<< (FB + 1)) - 1;
	localparam longint SAT_LO = -(64'sd1 <<< (FB + 1));
	localparam longint CYCLE_LIMIT = 64'd40000000;

	typedef struct {
		logic signed [15:0] x_value;
		logic signed [15:0] y_value;
		logic signed [15:0] param_t;
		logic converged;
		logic zero_slope;
	} easing_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [bes_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic signed [15:0] position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] x_value, y_value, param_t;
	logic converged, zero_slope;

	// shadow of the configuration registers
	logic [2:0] shadow_count;
	logic [31:0] shadow_points [6];
	logic [6:0] shadow_limit;

	// expected results, written by the sender, read by the checker
	easing_result_t expected_q [EXP_DEPTH];
	int exp_wr = 0, exp_rd = 0;
	int errors = 0;
	int results_seen = 0;
	int solves_sent = 0, evals_sent = 0;
	int conv_seen = 0, flat_seen = 0;
	longint cycles = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;

	bezier_easing_solver_core DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint sat_int(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	// round half up of v / 2^s, floor semantics via arithmetic shift
	function automatic longint round_shift(longint v, int s);
		if (s == 0) return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint q14_in(logic [15:0] raw);
		longint v;
		v = longint'($signed(raw));
		return sat_int(v);
	endfunction

	function automatic logic [15:0] q14_out(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic int curve_degree();
		return ((shadow_count > 6) ? 6 : int'(shadow_count)) + 1;
	endfunction

	// de Casteljau on one coordinate; slope taken from the last level
	function automatic longint bezier_coord(longint t, bit take_x, output longint slope);
		longint b [8];
		int n;
		n = curve_degree();
		b[0] = 0;
		for (int i = 1; i < n; i++)
			b[i] = q14_in(take_x ? shadow_points[i-1][31:16] : shadow_points[i-1][15:0]);
		b[n] = sat_int(ONE);
		slope = 0;
		for (int lvl = n; lvl >= 1; lvl--) begin
			if (lvl == 1) slope = longint'(n) * (b[1] - b[0]);
			for (int i = 0; i < lvl; i++)
				b[i] = sat_int(b[i] + round_shift(t * (b[i+1] - b[i]), FB));
		end
		return b[0];
	endfunction

	function automatic easing_result_t predict_easing(logic act, logic [15:0] pos);
		easing_result_t r;
		longint t, target, xt, d, delta, dy;
		int lim;
		r.converged = 1'b0;
		r.zero_slope = 1'b0;
		if (act == bes_pkg::ACT_EVAL) begin
			t = q14_in(pos);
			r.param_t = pos;
		end else begin
			target = q14_in(pos);
			lim = (shadow_limit == 0) ? 1 : int'(shadow_limit);
			t = ONE / 2;
			for (int k = 0; k < lim; k++) begin
				xt = bezier_coord(t, 1'b1, d);
				if (d == 0) begin
					r.zero_slope = 1'b1;
					break;
				end
				delta = ((xt - target) * ONE) / d;
				t = sat_int(t - delta);
				if (delta == 0) begin
					r.converged = 1'b1;
					break;
				end
			end
			r.param_t = q14_out(t);
		end
		r.x_value = q14_out(bezier_coord(t, 1'b1, d));
		r.y_value = q14_out(bezier_coord(t, 1'b0, dy));
		return r;
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		easing_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (exp_wr == exp_rd) begin
				$error("Result beat with nothing expected");
				errors++;
			end else begin
				e = expected_q[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (e.x_value !== x_value) begin
					$error("x_value expected %0d actual %0d", e.x_value, x_value);
					errors++;
				end
				if (e.y_value !== y_value) begin
					$error("y_value expected %0d actual %0d", e.y_value, y_value);
					errors++;
				end
				if (e.param_t !== param_t) begin
					$error("param_t expected %0d actual %0d", e.param_t, param_t);
					errors++;
				end
				if (e.converged !== converged) begin
					$error("converged expected %0d actual %0d", e.converged, converged);
					errors++;
				end
				if (e.zero_slope !== zero_slope) begin
					$error("zero_slope expected %0d actual %0d", e.zero_slope, zero_slope);
					errors++;
				end
				if (e.converged) conv_seen <= conv_seen + 1;
				if (e.zero_slope) flat_seen <= flat_seen + 1;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bes_pkg::REG_INNER_COUNT: shadow_count = data[2:0];
			bes_pkg::REG_ITER_LIMIT: shadow_limit = data[6:0];
			default: shadow_points[idx - bes_pkg::REG_POINT_ONE] = data;
		endcase
		@(posedge clk);
	endtask

	// drain: all results back, then a short idle margin
	task automatic settle();
		in_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_beat(logic act, logic [15:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		position <= pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q[exp_wr % EXP_DEPTH] = predict_easing(act, pos);
		exp_wr++;
		if (act == bes_pkg::ACT_EVAL) evals_sent++;
		else solves_sent++;
	endtask

	function automatic logic [15:0] rand_q14();
		case ($urandom_range(3))
			0: return 16'($urandom_range(16384));
			1: return 16'($urandom_range(8192) + 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_point();
		if ($urandom_range(3) == 0) return $urandom;
		return {16'($urandom_range(16384)), 16'($urandom_range(16384))};
	endfunction

	task automatic test_reset_defaults();
		send_beat(bes_pkg::ACT_EVAL, 16'sd0);
		send_beat(bes_pkg::ACT_EVAL, 16'sd16384);
		send_beat(bes_pkg::ACT_SOLVE, 16'sd8192);
		send_beat(bes_pkg::ACT_SOLVE, 16'sd4000);
		settle();
	endtask

	task automatic test_directed_extremes();
		// classic ease curve, then the field extremes
		write_reg(bes_pkg::REG_INNER_COUNT, 32'd2);
		write_reg(bes_pkg::REG_POINT_ONE, {16'sd6881, 16'sd0});
		write_reg(IDX_W'(bes_pkg::REG_POINT_ONE + 1), {16'sd9503, 16'sd16384});
		write_reg(bes_pkg::REG_ITER_LIMIT, 32'd100);
		send_beat(bes_pkg::ACT_EVAL, 16'h7FFF);
		send_beat(bes_pkg::ACT_EVAL, 16'h8000);
		send_beat(bes_pkg::ACT_EVAL, 16'sd4096);
		send_beat(bes_pkg::ACT_SOLVE, 16'h7FFF);
		send_beat(bes_pkg::ACT_SOLVE, 16'h8000);
		send_beat(bes_pkg::ACT_SOLVE, 16'sd1638);
		settle();
		// zero iteration limit behaves as one step; limit reached
		write_reg(bes_pkg::REG_ITER_LIMIT, 32'd0);
		send_beat(bes_pkg::ACT_SOLVE, 16'sd2000);
		settle();
		write_reg(bes_pkg::REG_ITER_LIMIT, 32'd1);
		send_beat(bes_pkg::ACT_SOLVE, 16'sd15000);
		settle();
		// count above the maximum (clamped to six inner points); every inner x at the negative extreme, y at the positive
		write_reg(bes_pkg::REG_INNER_COUNT, 32'd7);
		write_reg(bes_pkg::REG_ITER_LIMIT, 32'd127);
		for (int i = 0; i < 6; i++)
			write_reg(IDX_W'(bes_pkg::REG_POINT_ONE + i), {16'h8000, 16'h7FFF});
		send_beat(bes_pkg::ACT_SOLVE, 16'sd9000);
		send_beat(bes_pkg::ACT_EVAL, 16'sd9000);
		settle();
		// inner x alternating one and zero: the x slope is zero at the starting t=0.5
		write_reg(bes_pkg::REG_INNER_COUNT, 32'd2);
		write_reg(bes_pkg::REG_POINT_ONE, {16'sd16384, 16'sd0});
		write_reg(IDX_W'(bes_pkg::REG_POINT_ONE + 1), {16'sd0, 16'sd16384});
		send_beat(bes_pkg::ACT_SOLVE, 16'sd8192);
		send_beat(bes_pkg::ACT_SOLVE, 16'sd100);
		settle();
	endtask

	task automatic test_random_curves(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			write_reg(bes_pkg::REG_INNER_COUNT, 32'($urandom_range(7)));
			for (int i = 0; i < 6; i++)
				write_reg(IDX_W'(bes_pkg::REG_POINT_ONE + i), rand_point());
			case ($urandom_range(3))
				0: write_reg(bes_pkg::REG_ITER_LIMIT, 32'd100);
				1: write_reg(bes_pkg::REG_ITER_LIMIT, 32'($urandom_range(127)));
				default: write_reg(bes_pkg::REG_ITER_LIMIT, 32'($urandom_range(8, 1)));
			endcase
			for (int k = 0; k < per_phase; k++)
				send_beat(1'($urandom_range(1)), rand_q14());
			settle();
		end
	endtask

	initial begin
		shadow_count = '0;
		shadow_limit = bes_pkg::LIMIT_RESET;
		foreach (shadow_points[i]) shadow_points[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		send_idle_pct = 35;
		recv_idle_pct = 61;
		test_reset_defaults();
		test_directed_extremes();
		test_random_curves(10, 27);
		send_idle_pct = 61;
		recv_idle_pct = 35;
		test_random_curves(10, 27);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_curves(10, 26);
		settle();
		$display("Covered %0d solves and %0d evaluations, %0d results checked",
			solves_sent, evals_sent, results_seen);
		$display("Converged solves %0d, zero-slope stops %0d", conv_seen, flat_seen);
		if (errors == 0 && exp_wr == exp_rd) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ----- bezier_easing_solver_core.f -----
rtl/bes_pkg.sv
rtl/bes_ctrl.sv
rtl/bes_dpath.sv
rtl/bezier_easing_solver_core.sv
tb/testbench.sv
